// ===== hdl/base_placement_cost_eval_core_assert.svh =====
`ifndef BASE_PLACEMENT_COST_EVAL_CORE_ASSERT_SVH
`define BASE_PLACEMENT_COST_EVAL_CORE_ASSERT_SVH

// same-cycle implication, checked on clk_i, quiet while in reset
`define BPCE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bpce assertion failed");

// next-cycle implication
`define BPCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bpce assertion failed");

`endif

// ===== hdl/bpce_pkg.sv =====
package bpce_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int RAD_W   = 15;
  localparam int STR_W   = 16;
  localparam int OUT_W   = 20;
  localparam int OBST_W  = 14;
  localparam int OBST_MAX = 8192;

  // square root: three result bits per stage
  localparam int SQRT_PER    = 3;
  localparam int SQRT_STAGES = (ROOT_W + SQRT_PER - 1) / SQRT_PER;

  // obstacle divider: quotient bit Q_W-1 flags saturation
  localparam int Q_W        = 20;
  localparam int NUM_W      = RAD_W + 24;
  localparam int DEN_W      = 2 * RAD_W;
  localparam int DIV_CMP_W  = DEN_W + Q_W;
  localparam int DIV_PER    = 3;
  localparam int DIV_STAGES = (Q_W + DIV_PER - 1) / DIV_PER;
  localparam int T_W        = Q_W - 1;
  localparam int T2_W       = 2 * T_W;
  localparam int PP_W       = STR_W + T_W;
  localparam int OBST_LAT   = DIV_STAGES + 4;

  typedef enum logic [2:0] {
    REG_START_XY  = 3'd0,
    REG_GOAL_XY   = 3'd1,
    REG_OPER_XY   = 3'd2,
    REG_OPER_HEAD = 3'd3,
    REG_REACH     = 3'd4,
    REG_RADIUS    = 3'd5,
    REG_STRENGTH  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [STR_W-1:0] strength;
  } obst_cfg_t;

  typedef struct packed {
    logic act;
    logic zero;
  } obst_flag_t;

  function automatic logic [DIFF_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                 logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

// ===== hdl/bpce_sqrt.sv =====
module bpce_sqrt import bpce_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   n_i,
  output logic [ROOT_W-1:0] root_o
);

  logic [SQ_W-1:0]   rem_q  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_q [SQRT_STAGES];
  logic [SQ_W-1:0]   rem_d  [SQRT_STAGES];
  logic [ROOT_W-1:0] root_d [SQRT_STAGES];

  // digit-by-digit root, rem holds n minus root squared
  always_comb begin
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W:0]     trial;
    int                k;
    for (int s = 0; s < SQRT_STAGES; s++) begin
      rem  = (s == 0) ? n_i : rem_q[(s == 0) ? 0 : s - 1];
      root = (s == 0) ? '0 : root_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < SQRT_PER; j++) begin
        k = ROOT_W - 1 - SQRT_PER * s - j;
        if (k >= 0) begin
          trial = ((SQ_W + 1)'(root) << (k + 1)) + ((SQ_W + 1)'(1) << (2 * k));
          if ({1'b0, rem} >= trial) begin
            rem  = rem - trial[SQ_W-1:0];
            root = root | (ROOT_W'(1) << k);
          end
        end
      end
      rem_d[s]  = rem;
      root_d[s] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign root_o = root_q[SQRT_STAGES-1];

endmodule

// ===== hdl/bpce_obst.sv =====
module bpce_obst import bpce_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [ROOT_W-1:0] d_i,
  input  obst_cfg_t         cfg_i,
  output logic [OBST_W-1:0] cost_o
);

  // setup stage
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  obst_flag_t       flg_q;
  logic [RAD_W-1:0] rdiff;

  assign rdiff = cfg_i.radius - d_i[RAD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q      <= {rdiff, 24'd0};
      den_q      <= DEN_W'(d_i[RAD_W-1:0]) * DEN_W'(cfg_i.radius);
      flg_q.act  <= (d_i < ROOT_W'(cfg_i.radius)) && (cfg_i.strength != '0);
      flg_q.zero <= (d_i == '0);
    end
  end

  // restoring divider
  logic [NUM_W-1:0] rem_q [DIV_STAGES];
  logic [DEN_W-1:0] dv_q  [DIV_STAGES];
  logic [Q_W-1:0]   quo_q [DIV_STAGES];
  obst_flag_t       df_q  [DIV_STAGES];
  logic [NUM_W-1:0] rem_d [DIV_STAGES];
  logic [Q_W-1:0]   quo_d [DIV_STAGES];

  always_comb begin
    logic [NUM_W-1:0]     rem;
    logic [Q_W-1:0]       quo;
    logic [DEN_W-1:0]     den;
    logic [DIV_CMP_W-1:0] cmp;
    int                   k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      rem = (s == 0) ? num_q : rem_q[(s == 0) ? 0 : s - 1];
      quo = (s == 0) ? '0 : quo_q[(s == 0) ? 0 : s - 1];
      den = (s == 0) ? den_q : dv_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < DIV_PER; j++) begin
        k = Q_W - 1 - DIV_PER * s - j;
        if (k >= 0) begin
          cmp = DIV_CMP_W'(den) << k;
          if (DIV_CMP_W'(rem) >= cmp) begin
            rem = rem - cmp[NUM_W-1:0];
            quo = quo | (Q_W'(1) << k);
          end
        end
      end
      rem_d[s] = rem;
      quo_d[s] = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        dv_q[s]  <= (s == 0) ? den_q : dv_q[(s == 0) ? 0 : s - 1];
        df_q[s]  <= (s == 0) ? flg_q : df_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // square, scale, clamp
  logic [T2_W-1:0]  t2_q;
  logic             sat1_q, sat2_q;
  obst_flag_t       f1_q, f2_q;
  logic [PP_W-1:0]  plo_q, phi_q;
  logic [OBST_W-1:0] cost_q;
  logic [T_W-1:0]   t;
  logic [PP_W+T_W:0] psum;
  logic [PP_W+T_W-25:0] scaled;

  assign t      = quo_q[DIV_STAGES-1][T_W-1:0];
  assign psum   = (PP_W + T_W + 1)'({phi_q, {T_W{1'b0}}}) + (PP_W + T_W + 1)'(plo_q);
  assign scaled = psum[PP_W+T_W:25];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_q   <= T2_W'(t) * T2_W'(t);
      sat1_q <= quo_q[DIV_STAGES-1][Q_W-1];
      f1_q   <= df_q[DIV_STAGES-1];
      plo_q  <= PP_W'(cfg_i.strength) * PP_W'(t2_q[T_W-1:0]);
      phi_q  <= PP_W'(cfg_i.strength) * PP_W'(t2_q[T2_W-1:T_W]);
      sat2_q <= sat1_q;
      f2_q   <= f1_q;
      if (!f2_q.act) begin
        cost_q <= '0;
      end else if (f2_q.zero || sat2_q || scaled > OBST_MAX) begin
        cost_q <= OBST_W'(OBST_MAX);
      end else begin
        cost_q <= scaled[OBST_W-1:0];
      end
    end
  end

  assign cost_o = cost_q;

endmodule

// ===== hdl/base_placement_cost_eval_core.sv =====
// placement cost evaluator for a mobile base candidate position
// input channel: in_valid_i / in_stall_o carry cand_x_i, cand_y_i (signed Q4.12)
// output channel: out_valid_o / out_stall_i carry the total and four cost terms, all
//   unsigned, Q8.12 but obstacle Q2.12; one result transaction per input transaction
// a transaction moves on a rising edge with valid high and stall low
// throughput: one transaction per cycle while the receiver does not stall;
//   the pipeline is set by the 6-stage square root and the 7-stage obstacle
//   divider, three bits per stage each
// when the receiver stalls with a result pending, the whole pipeline holds
//   and in_stall_o rises in the same cycle; nothing is dropped or repeated
// registers live on the apb port at byte address 4*index, pready is tied high;
//   write them only while no transaction is in flight
// reset clears all valid bits and loads the default register values
module base_placement_cost_eval_core import bpce_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [COORD_W-1:0]  cand_x_i,
  input  logic [COORD_W-1:0]  cand_y_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    total_cost_o,
  output logic [OUT_W-1:0]    operator_cost_o,
  output logic [OUT_W-1:0]    travel_cost_o,
  output logic [OUT_W-1:0]    reach_cost_o,
  output logic [OBST_W-1:0]   obstacle_cost_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int T_ROOT = 3 + SQRT_STAGES;
  localparam int T_COST = T_ROOT + OBST_LAT;
  localparam int N_STG  = T_COST + 2;
  localparam int OP_LEN = T_COST - 1;
  localparam int TR_LEN = T_COST - T_ROOT;

  // configuration registers
  logic [31:0]      start_q, goal_q, oper_q, head_q;
  logic [RAD_W-1:0] reach_q, radius_q;
  logic [STR_W-1:0] strength_q;
  reg_idx_e         idx;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= 32'h1000_1000;
      goal_q     <= 32'h0000_0000;
      oper_q     <= 32'hF99A_0000;
      head_q     <= 32'h2D46_2D3D;
      reach_q    <= RAD_W'(2048);
      radius_q   <= RAD_W'(1229);
      strength_q <= STR_W'(4096);
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_START_XY:  start_q    <= pwdata;
        REG_GOAL_XY:   goal_q     <= pwdata;
        REG_OPER_XY:   oper_q     <= pwdata;
        REG_OPER_HEAD: head_q     <= pwdata;
        REG_REACH:     reach_q    <= pwdata[RAD_W-1:0];
        REG_RADIUS:    radius_q   <= pwdata[RAD_W-1:0];
        REG_STRENGTH:  strength_q <= pwdata[STR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_XY:  prdata = start_q;
      REG_GOAL_XY:   prdata = goal_q;
      REG_OPER_XY:   prdata = oper_q;
      REG_OPER_HEAD: prdata = head_q;
      REG_REACH:     prdata = 32'(reach_q);
      REG_RADIUS:    prdata = 32'(radius_q);
      REG_STRENGTH:  prdata = 32'(strength_q);
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic             en;
  logic [N_STG-1:0] v_q;

  assign en         = !(v_q[N_STG-1] && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[N_STG-2:0], in_valid_i};
    end
  end

  // stage 0: input register
  logic [COORD_W-1:0] cx_q, cy_q;

  // stage 1: differences and heading products
  logic [DIFF_W-1:0]        adx_q [3];
  logic [DIFF_W-1:0]        ady_q [3];
  logic signed [2*COORD_W:0] pa_q, pb_q;
  logic signed [COORD_W-1:0] co, si;
  logic signed [DIFF_W-1:0]  ody, odx;

  assign co  = $signed(head_q[31:16]);
  assign si  = $signed(head_q[15:0]);
  assign ody = $signed({oper_q[15], oper_q[15:0]}) - $signed({cy_q[COORD_W-1], cy_q});
  assign odx = $signed({oper_q[31], oper_q[31:16]}) - $signed({cx_q[COORD_W-1], cx_q});

  // stage 2: squares and operator term
  logic [SQ_W-1:0]          sqx_q [3];
  logic [SQ_W-1:0]          sqy_q [3];
  logic signed [2*COORD_W+1:0] pdiff;
  logic [2*COORD_W+1:0]     pmag;
  logic [2*COORD_W+2:0]     pround;

  assign pdiff  = (2 * COORD_W + 2)'(pa_q) - (2 * COORD_W + 2)'(pb_q);
  assign pmag   = pdiff[2*COORD_W+1] ? (2 * COORD_W + 2)'(-pdiff)
                                     : (2 * COORD_W + 2)'(pdiff);
  assign pround = (2 * COORD_W + 3)'(pmag) + (2 * COORD_W + 3)'(32768);

  logic [OUT_W-1:0] op_q [OP_LEN];

  // stage 3: sums of squares into the root units
  logic [SQ_W-1:0]   n_q  [3];
  logic [ROOT_W-1:0] root [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q     <= cand_x_i;
      cy_q     <= cand_y_i;
      adx_q[0] <= abs_diff(cx_q, start_q[31:16]);
      ady_q[0] <= abs_diff(cy_q, start_q[15:0]);
      adx_q[1] <= abs_diff(cx_q, goal_q[31:16]);
      ady_q[1] <= abs_diff(cy_q, goal_q[15:0]);
      adx_q[2] <= abs_diff(cx_q, oper_q[31:16]);
      ady_q[2] <= abs_diff(cy_q, oper_q[15:0]);
      pa_q     <= (2 * COORD_W + 1)'(co) * (2 * COORD_W + 1)'(ody);
      pb_q     <= (2 * COORD_W + 1)'(si) * (2 * COORD_W + 1)'(odx);
      for (int i = 0; i < 3; i++) begin
        sqx_q[i] <= SQ_W'(adx_q[i]) * SQ_W'(adx_q[i]);
        sqy_q[i] <= SQ_W'(ady_q[i]) * SQ_W'(ady_q[i]);
        n_q[i]   <= sqx_q[i] + sqy_q[i];
      end
      op_q[0] <= OUT_W'(pround[2*COORD_W+2:16]);
      for (int i = 1; i < OP_LEN; i++) begin
        op_q[i] <= op_q[i-1];
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_root
    bpce_sqrt u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .n_i    (n_q[g]),
      .root_o (root[g])
    );
  end

  // travel and reach terms, then delay to meet the obstacle term
  logic [ROOT_W-1:0] dev;
  logic [ROOT_W+1:0] dev3;
  logic [OUT_W-1:0]  tr_q [TR_LEN];
  logic [OUT_W-1:0]  re_q [TR_LEN];

  assign dev  = (root[1] > ROOT_W'(reach_q)) ? root[1] - ROOT_W'(reach_q)
                                             : ROOT_W'(reach_q) - root[1];
  assign dev3 = (ROOT_W + 2)'(dev) * (ROOT_W + 2)'(3) + (ROOT_W + 2)'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_q[0] <= OUT_W'(root[0]);
      re_q[0] <= OUT_W'(dev3[ROOT_W+1:1]);
      for (int i = 1; i < TR_LEN; i++) begin
        tr_q[i] <= tr_q[i-1];
        re_q[i] <= re_q[i-1];
      end
    end
  end

  obst_cfg_t         ocfg;
  logic [OBST_W-1:0] obst;

  assign ocfg.radius   = radius_q;
  assign ocfg.strength = strength_q;

  bpce_obst u_obst (
    .clk_i  (clk_i),
    .en_i   (en),
    .d_i    (root[2]),
    .cfg_i  (ocfg),
    .cost_o (obst)
  );

  // output register
  logic [OUT_W+1:0]  tsum;
  logic [OUT_W-1:0]  tot_q, opo_q, tro_q, reo_q;
  logic [OBST_W-1:0] obo_q;

  assign tsum = (OUT_W + 2)'(op_q[OP_LEN-1]) + (OUT_W + 2)'(tr_q[TR_LEN-1])
              + (OUT_W + 2)'(re_q[TR_LEN-1]) + (OUT_W + 2)'(obst);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q <= (tsum[OUT_W+1:OUT_W] != '0) ? '1 : tsum[OUT_W-1:0];
      opo_q <= op_q[OP_LEN-1];
      tro_q <= tr_q[TR_LEN-1];
      reo_q <= re_q[TR_LEN-1];
      obo_q <= obst;
    end
  end

  assign out_valid_o     = v_q[N_STG-1];
  assign total_cost_o    = tot_q;
  assign operator_cost_o = opo_q;
  assign travel_cost_o   = tro_q;
  assign reach_cost_o    = reo_q;
  assign obstacle_cost_o = obo_q;

endmodule

// ===== hdl/bpce_checker.sv =====
`include "base_placement_cost_eval_core_assert.svh"

module bpce_checker import bpce_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [OUT_W-1:0]   total_cost_o,
  input logic [OUT_W-1:0]   operator_cost_o,
  input logic [OUT_W-1:0]   travel_cost_o,
  input logic [OUT_W-1:0]   reach_cost_o,
  input logic [OBST_W-1:0]  obstacle_cost_o
);

  // a held result stays valid and its total unchanged
  `BPCE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `BPCE_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(total_cost_o))
  // input side only backs up when a result is stuck
  `BPCE_ASSERT_NOW(a_in_stall, in_stall_o, out_valid_o && out_stall_i)
  `BPCE_ASSERT_NOW(a_obst_max, out_valid_o, obstacle_cost_o <= OBST_W'(OBST_MAX))
  // saturating sum never drops below a term
  `BPCE_ASSERT_NOW(a_total_ge, out_valid_o,
    total_cost_o >= operator_cost_o && total_cost_o >= travel_cost_o &&
    total_cost_o >= reach_cost_o && total_cost_o >= OUT_W'(obstacle_cost_o))

endmodule

bind base_placement_cost_eval_core bpce_checker u_bpce_checker (.*);
